/* design/blade_section_cylinder_wrap_unit_assert.svh */
// Assertion macros for the cylinder wrap unit.
// Used by the port checker; expects clk and arst_n in scope.
`ifndef BLADE_SECTION_CYLINDER_WRAP_UNIT_ASSERT_SVH
`define BLADE_SECTION_CYLINDER_WRAP_UNIT_ASSERT_SVH
// same-cycle implication
`define BSCW_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);
// next-cycle implication
`define BSCW_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);
`endif

/* design/bscw_pkg.sv */
// Shared constants and helpers for the cylinder wrap unit.
// Angle constants in Q.30, CORDIC table, latency and rounding helpers.
`timescale 1ns / 1ps
`default_nettype none
package bscw_pkg;
	localparam int ANG_FRAC = 30;
	localparam int CORDIC_TAB = 30;
	localparam int RAD_W = 31;
	localparam int DIV_W = 63;
	localparam int DIV_LAT = DIV_W + 1;
	localparam int XW = 34;

	localparam logic signed [XW-1:0] CORDIC_GAIN = 34'sd652032874;
	localparam logic [34:0] PI_Q30 = 35'd3373259426;
	localparam logic [34:0] TWO_PI_Q30 = 35'd6746518852;
	localparam logic [34:0] HALF_PI_Q30 = 35'd1686629713;

	localparam logic [30:0] ATAN_Q30 [CORDIC_TAB] = '{
		31'd843314857, 31'd497837829, 31'd263043837, 31'd133525159, 31'd67021687,
		31'd33543516, 31'd16775851, 31'd8388437, 31'd4194283, 31'd2097149,
		31'd1048576, 31'd524288, 31'd262144, 31'd131072, 31'd65536, 31'd32768,
		31'd16384, 31'd8192, 31'd4096, 31'd2048, 31'd1024, 31'd512, 31'd256,
		31'd128, 31'd64, 31'd32, 31'd16, 31'd8, 31'd4, 31'd2
	};

	// range reduction stages for an angle magnitude of mw bits
	function automatic int sc_red(input int mw);
		return (mw > 33) ? mw - 32 : 1;
	endfunction

	function automatic int sc_steps(input int st);
		return (st < CORDIC_TAB) ? st : CORDIC_TAB;
	endfunction

	function automatic int sc_lat(input int mw, input int st);
		return sc_red(mw) + sc_steps(st) + 4;
	endfunction

	function automatic int lane_lat(input int st);
		return 2 + DIV_LAT + sc_lat(DIV_W, st) + 2;
	endfunction

	// add half and floor-shift out the Q.30 fraction
	function automatic logic signed [65:0] round30(input logic signed [65:0] v);
		return (v + (66'sd1 <<< (ANG_FRAC - 1))) >>> ANG_FRAC;
	endfunction

	function automatic logic [31:0] sat32(input logic signed [65:0] v);
		if (v > 66'sd2147483647)
			return 32'h7fff_ffff;
		if (v < -66'sd2147483648)
			return 32'h8000_0000;
		return v[31:0];
	endfunction
endpackage
`default_nettype wire

/* design/bscw_sincos.sv */
// Pipelined sine/cosine: modulo-2pi reduction one bit per stage, quadrant fold,
// then one CORDIC rotation per stage. Uses bscw_pkg.
`timescale 1ns / 1ps
`default_nettype none
module bscw_sincos #(
	parameter int MW_IN = 63,
	parameter int STEPS = 20
) (
	input  wire logic                            clk,
	input  wire logic                            en,
	input  wire logic [MW_IN-1:0]                ang_mag,
	input  wire logic                            ang_neg,
	output logic signed [bscw_pkg::XW-1:0]       sin_o,
	output logic signed [bscw_pkg::XW-1:0]       cos_o
);
	localparam int RED = bscw_pkg::sc_red(MW_IN);
	localparam int N = bscw_pkg::sc_steps(STEPS);
	localparam int MAGW = (MW_IN > 35) ? MW_IN : 35;
	localparam int AW = 36;
	localparam int XW = bscw_pkg::XW;
	localparam logic signed [AW-1:0] PI_S = AW'(bscw_pkg::PI_Q30);
	localparam logic signed [AW-1:0] TWO_PI_S = AW'(bscw_pkg::TWO_PI_Q30);
	localparam logic signed [AW-1:0] HALF_PI_S = AW'(bscw_pkg::HALF_PI_Q30);

	logic [MAGW-1:0] red_s [RED+1];
	logic [RED:0] neg_s;
	logic signed [AW-1:0] rem_v, a1_v, a1_s, a2_v;
	logic flip_v;
	logic signed [XW-1:0] x_s [N+1];
	logic signed [XW-1:0] y_s [N+1];
	logic signed [AW-1:0] z_s [N+1];
	logic [N:0] flip_s;
	logic signed [XW-1:0] sin_s, cos_s;

	always_ff @(posedge clk) begin
		if (en) begin
			red_s[0] <= MAGW'(ang_mag);
			neg_s[0] <= ang_neg;
		end
	end

	// conditional subtract of 2pi<<k, highest k first
	for (genvar j = 1; j <= RED; j++) begin : g_red
		localparam logic [MAGW-1:0] SUB = MAGW'(bscw_pkg::TWO_PI_Q30) << (RED - j);
		always_ff @(posedge clk) begin
			if (en) begin
				if (red_s[j-1] >= SUB)
					red_s[j] <= red_s[j-1] - SUB;
				else
					red_s[j] <= red_s[j-1];
				neg_s[j] <= neg_s[j-1];
			end
		end
	end

	// truncating remainder takes the sign of the angle, then into [-pi, pi]
	always_comb begin
		rem_v = signed'(AW'(red_s[RED][32:0]));
		if (neg_s[RED])
			rem_v = -rem_v;
		a1_v = rem_v;
		if (rem_v > PI_S)
			a1_v = rem_v - TWO_PI_S;
		else if (rem_v < -PI_S)
			a1_v = rem_v + TWO_PI_S;
	end

	always_ff @(posedge clk) begin
		if (en)
			a1_s <= a1_v;
	end

	always_comb begin
		a2_v = a1_s;
		flip_v = 1'b0;
		if (a1_s > HALF_PI_S) begin
			a2_v = a1_s - PI_S;
			flip_v = 1'b1;
		end else if (a1_s < -HALF_PI_S) begin
			a2_v = a1_s + PI_S;
			flip_v = 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			x_s[0] <= bscw_pkg::CORDIC_GAIN;
			y_s[0] <= '0;
			z_s[0] <= a2_v;
			flip_s[0] <= flip_v;
		end
	end

	for (genvar i = 0; i < N; i++) begin : g_rot
		localparam logic signed [AW-1:0] ATAN = AW'(bscw_pkg::ATAN_Q30[i]);
		always_ff @(posedge clk) begin
			if (en) begin
				if (z_s[i] >= 0) begin
					x_s[i+1] <= x_s[i] - (y_s[i] >>> i);
					y_s[i+1] <= y_s[i] + (x_s[i] >>> i);
					z_s[i+1] <= z_s[i] - ATAN;
				end else begin
					x_s[i+1] <= x_s[i] + (y_s[i] >>> i);
					y_s[i+1] <= y_s[i] - (x_s[i] >>> i);
					z_s[i+1] <= z_s[i] + ATAN;
				end
				flip_s[i+1] <= flip_s[i];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sin_s <= flip_s[N] ? -y_s[N] : y_s[N];
			cos_s <= flip_s[N] ? -x_s[N] : x_s[N];
		end
	end

	assign sin_o = sin_s;
	assign cos_o = cos_s;
endmodule
`default_nettype wire

/* design/bscw_div.sv */
// Pipelined restoring divider, one quotient bit per stage, truncating.
// Magnitude in, magnitude out; sign travels alongside. Uses bscw_pkg.
`timescale 1ns / 1ps
`default_nettype none
module bscw_div (
	input  wire logic                          clk,
	input  wire logic                          en,
	input  wire logic [bscw_pkg::DIV_W-1:0]    num_mag,
	input  wire logic                          num_neg,
	input  wire logic [bscw_pkg::RAD_W-1:0]    den,
	output logic [bscw_pkg::DIV_W-1:0]         quo,
	output logic                               quo_neg
);
	localparam int W = bscw_pkg::DIV_W;
	localparam int RW = bscw_pkg::RAD_W;

	logic [W-1:0] nq_s [W+1];
	logic [RW-1:0] rem_s [W+1];
	logic [RW-1:0] den_s [W+1];
	logic [W:0] neg_s;

	always_ff @(posedge clk) begin
		if (en) begin
			nq_s[0] <= num_mag;
			rem_s[0] <= '0;
			den_s[0] <= den;
			neg_s[0] <= num_neg;
		end
	end

	for (genvar j = 1; j <= W; j++) begin : g_stage
		logic [RW:0] tr;
		assign tr = {rem_s[j-1], nq_s[j-1][W-1]};
		always_ff @(posedge clk) begin
			if (en) begin
				if (tr >= {1'b0, den_s[j-1]}) begin
					rem_s[j] <= RW'(tr - {1'b0, den_s[j-1]});
					nq_s[j] <= {nq_s[j-1][W-2:0], 1'b1};
				end else begin
					rem_s[j] <= tr[RW-1:0];
					nq_s[j] <= {nq_s[j-1][W-2:0], 1'b0};
				end
				den_s[j] <= den_s[j-1];
				neg_s[j] <= neg_s[j-1];
			end
		end
	end

	assign quo = nq_s[W];
	assign quo_neg = neg_s[W];
endmodule
`default_nettype wire

/* design/bscw_lane.sv */
// One offset lane: rotate by pitch, divide arc by radius, wrap onto cylinder.
// Uses bscw_pkg, bscw_div and bscw_sincos.
`timescale 1ns / 1ps
`default_nettype none
module bscw_lane #(
	parameter int STEPS = 20
) (
	input  wire logic                              clk,
	input  wire logic                              en,
	input  wire logic signed [31:0]                thick,
	input  wire logic signed [32:0]                chord_d,
	input  wire logic signed [bscw_pkg::XW-1:0]    sin_p,
	input  wire logic signed [bscw_pkg::XW-1:0]    cos_p,
	input  wire logic [bscw_pkg::RAD_W-1:0]        radius,
	output logic [31:0]                            out_x,
	output logic [31:0]                            out_y,
	output logic [31:0]                            out_z
);
	localparam int RW = bscw_pkg::RAD_W;
	localparam int DW = bscw_pkg::DIV_W;
	localparam int SCL = bscw_pkg::sc_lat(DW, STEPS);
	localparam int RDL = bscw_pkg::DIV_LAT + SCL;
	localparam int ZDL = RDL + 2;

	logic signed [65:0] tc_s1, ts_s1, dc_s1, ds_s1;
	logic [RW-1:0] rad_s1, rad_s2;
	logic signed [63:0] zf_s2, uf_s2;
	logic [DW-1:0] uf_mag;
	logic [DW-1:0] quo;
	logic quo_neg;
	logic signed [bscw_pkg::XW-1:0] sin_w, cos_w;
	logic [RW-1:0] rad_q [RDL];
	logic [31:0] z_q [ZDL];
	logic signed [65:0] rs_s3, rc_s3;
	logic [31:0] x_s4, y_s4;

	always_ff @(posedge clk) begin
		if (en) begin
			tc_s1 <= 66'(thick) * 66'(cos_p);
			ts_s1 <= 66'(thick) * 66'(sin_p);
			dc_s1 <= 66'(chord_d) * 66'(cos_p);
			ds_s1 <= 66'(chord_d) * 66'(sin_p);
			rad_s1 <= radius;
			zf_s2 <= 64'(tc_s1 - ds_s1);
			uf_s2 <= 64'(dc_s1 + ts_s1);
			rad_s2 <= rad_s1;
		end
	end

	assign uf_mag = uf_s2[63] ? DW'(-uf_s2) : uf_s2[DW-1:0];

	bscw_div u_div (
		.clk     (clk),
		.en      (en),
		.num_mag (uf_mag),
		.num_neg (uf_s2[63]),
		.den     (rad_s2),
		.quo     (quo),
		.quo_neg (quo_neg)
	);

	// omega = -(u / r): its sign is opposite to the quotient's
	bscw_sincos #(
		.MW_IN (DW),
		.STEPS (STEPS)
	) u_trig (
		.clk     (clk),
		.en      (en),
		.ang_mag (quo),
		.ang_neg (~quo_neg),
		.sin_o   (sin_w),
		.cos_o   (cos_w)
	);

	always_ff @(posedge clk) begin
		if (en) begin
			rad_q[0] <= rad_s2;
			z_q[0] <= bscw_pkg::sat32(bscw_pkg::round30(66'(zf_s2)));
			for (int k = 1; k < RDL; k++)
				rad_q[k] <= rad_q[k-1];
			for (int k = 1; k < ZDL; k++)
				z_q[k] <= z_q[k-1];
		end
	end

	// s3/s4 count from the trig output
	always_ff @(posedge clk) begin
		if (en) begin
			rs_s3 <= 66'(signed'({1'b0, rad_q[RDL-1]})) * 66'(sin_w);
			rc_s3 <= 66'(signed'({1'b0, rad_q[RDL-1]})) * 66'(cos_w);
			x_s4 <= bscw_pkg::sat32(-bscw_pkg::round30(rs_s3));
			y_s4 <= bscw_pkg::sat32(bscw_pkg::round30(rc_s3));
		end
	end

	assign out_x = x_s4;
	assign out_y = y_s4;
	assign out_z = z_q[ZDL-1];
endmodule
`default_nettype wire

/* design/blade_section_cylinder_wrap_unit.sv */
// Cylinder wrap of a pitched blade-section station; back and face lanes run in parallel.
// Throughput: one request per cycle while the output is not stalled.
// The 63-stage divider and three CORDIC pipelines set depth.
// Whole pipeline stalls only when its last stage and the output register both hold data and m_tready is low.
// Reset (arst_n low, async) clears valid and error flag bits only; the data path carries no reset.
`timescale 1ns / 1ps
`default_nettype none
module blade_section_cylinder_wrap_unit #(
	parameter int FRAC_BITS = 16,
	parameter int TRIG_STEPS = 20
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          s_tvalid,
	output logic               s_tready,
	// radius[30:0], skew_offset[62:31], pitch_angle[82:63], station_pos[114:83],
	// back_thick[146:115], face_thick[178:147], zero pad[183:179]
	input  wire logic [183:0]  s_tdata,
	output logic               m_tvalid,
	input  wire logic          m_tready,
	// back_x[31:0], back_y[63:32], back_z[95:64], face_x[127:96], face_y[159:128],
	// face_z[191:160]
	output logic [191:0]       m_tdata,
	// error_flag[0]
	output logic               m_tuser
);
	localparam int RW = bscw_pkg::RAD_W;
	localparam int XW = bscw_pkg::XW;
	localparam int PSH = bscw_pkg::ANG_FRAC - FRAC_BITS;
	localparam int PW = 20 + PSH;
	localparam int SCP = bscw_pkg::sc_lat(PW, TRIG_STEPS);
	localparam int TOT = SCP + bscw_pkg::lane_lat(TRIG_STEPS);

	logic [RW-1:0] radius;
	logic signed [31:0] skew_offset, station_pos, back_thick, face_thick;
	logic signed [19:0] pitch_angle;
	logic [19:0] pitch_mag;
	logic [PW-1:0] pitch_shift;
	logic en, tail_v, out_free;
	logic [TOT-1:0] vld_q;
	logic [TOT-1:0] err_q;
	logic signed [32:0] dist_q [SCP];
	logic signed [31:0] tb_q [SCP];
	logic signed [31:0] tf_q [SCP];
	logic [RW-1:0] rad_q [SCP];
	logic signed [XW-1:0] sin_p, cos_p;
	logic [31:0] bx, by, bz, fx, fy, fz;
	logic out_v_q, out_err_q;
	logic [191:0] out_data_q;

	assign radius = s_tdata[30:0];
	assign skew_offset = s_tdata[62:31];
	assign pitch_angle = s_tdata[82:63];
	assign station_pos = s_tdata[114:83];
	assign back_thick = s_tdata[146:115];
	assign face_thick = s_tdata[178:147];

	assign tail_v = vld_q[TOT-1];
	assign out_free = ~out_v_q | m_tready;
	assign en = ~tail_v | out_free;
	assign s_tready = en;

	assign pitch_mag = pitch_angle[19] ? 20'(-pitch_angle) : pitch_angle;
	assign pitch_shift = PW'(pitch_mag) << PSH;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
			err_q <= '0;
		end else if (en) begin
			vld_q <= {vld_q[TOT-2:0], s_tvalid};
			err_q <= {err_q[TOT-2:0], (radius == '0)};
		end
	end

	// hold station data while the pitch trig runs
	always_ff @(posedge clk) begin
		if (en) begin
			dist_q[0] <= 33'(station_pos) - 33'(skew_offset);
			tb_q[0] <= back_thick;
			tf_q[0] <= face_thick;
			rad_q[0] <= radius;
			for (int k = 1; k < SCP; k++) begin
				dist_q[k] <= dist_q[k-1];
				tb_q[k] <= tb_q[k-1];
				tf_q[k] <= tf_q[k-1];
				rad_q[k] <= rad_q[k-1];
			end
		end
	end

	bscw_sincos #(
		.MW_IN (PW),
		.STEPS (TRIG_STEPS)
	) u_pitch (
		.clk     (clk),
		.en      (en),
		.ang_mag (pitch_shift),
		.ang_neg (pitch_angle[19]),
		.sin_o   (sin_p),
		.cos_o   (cos_p)
	);

	bscw_lane #(.STEPS(TRIG_STEPS)) u_back (
		.clk     (clk),
		.en      (en),
		.thick   (tb_q[SCP-1]),
		.chord_d (dist_q[SCP-1]),
		.sin_p   (sin_p),
		.cos_p   (cos_p),
		.radius  (rad_q[SCP-1]),
		.out_x   (bx),
		.out_y   (by),
		.out_z   (bz)
	);

	bscw_lane #(.STEPS(TRIG_STEPS)) u_face (
		.clk     (clk),
		.en      (en),
		.thick   (tf_q[SCP-1]),
		.chord_d (dist_q[SCP-1]),
		.sin_p   (sin_p),
		.cos_p   (cos_p),
		.radius  (rad_q[SCP-1]),
		.out_x   (fx),
		.out_y   (fy),
		.out_z   (fz)
	);

	// merge lanes; zero radius forces all points to zero
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_v_q <= 1'b0;
		else if (out_free)
			out_v_q <= tail_v;
	end

	always_ff @(posedge clk) begin
		if (out_free) begin
			out_err_q <= err_q[TOT-1];
			out_data_q <= err_q[TOT-1] ? '0 : {fz, fy, fx, bz, by, bx};
		end
	end

	assign m_tvalid = out_v_q;
	assign m_tdata = out_data_q;
	assign m_tuser = out_err_q;
endmodule
`default_nettype wire

/* design/bscw_checker.sv */
// Port-level checks for the cylinder wrap unit, bound to the top level.
// Uses the assertion macros from blade_section_cylinder_wrap_unit_assert.svh.
`timescale 1ns / 1ps
`default_nettype none
`include "blade_section_cylinder_wrap_unit_assert.svh"
module bscw_checker (
	input wire logic          clk,
	input wire logic          arst_n,
	input wire logic          s_tvalid,
	input wire logic          s_tready,
	input wire logic          m_tvalid,
	input wire logic          m_tready,
	input wire logic [191:0]  m_tdata,
	input wire logic          m_tuser
);
	// a stalled result keeps its payload
	`BSCW_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser), "output changed while stalled")
	// zero radius gives zero points
	`BSCW_ASSERT_NOW(a_err_zero, m_tvalid && m_tuser, m_tdata == 192'd0, "error result carries nonzero points")
	// input side backs off only when the output is blocked
	`BSCW_ASSERT_NOW(a_stall_cause, !s_tready, m_tvalid && !m_tready, "input stalled without output backpressure")
endmodule

bind blade_section_cylinder_wrap_unit bscw_checker u_bscw_checker (.*);
`default_nettype wire

/* verif/tb.sv */
// Self-checking bench for the cylinder wrap unit: directed, random and backpressure phases.
// Depends on bscw_pkg and blade_section_cylinder_wrap_unit; predicts each station internally.
`timescale 1ns / 1ps
module tb;
	localparam int FRAC = 16;
	localparam int STEPS = 20;
	localparam longint GAIN = 64'sd652032874;
	localparam longint PI_A = 64'sd3373259426;
	localparam longint TWO_PI_A = 64'sd6746518852;
	localparam longint HALF_PI_A = 64'sd1686629713;
	localparam int DRAIN_CYCLES = 200;
	localparam int CYCLE_LIMIT = 400000;

	typedef struct {
		logic [30:0] radius;
		logic [31:0] skew;
		logic [19:0] pitch;
		logic [31:0] pos;
		logic [31:0] back;
		logic [31:0] face;
	} station_t;

	typedef struct {
		logic [31:0] coord [6];
		logic        err;
	} wrapped_pts_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_tvalid = 1'b0;
	logic s_tready;
	logic [183:0] s_tdata = '0;
	logic m_tvalid;
	logic m_tready = 1'b0;
	logic [191:0] m_tdata;
	logic m_tuser;

	wrapped_pts_t pts_pending [$];
	int tx_idle_pct = 0;
	int rx_idle_pct = 0;
	int stall_reqs = 0;
	int stall_served = 0;
	int stall_cnt = 0;
	int mismatches = 0;
	int results_seen = 0;
	int requests_sent = 0;
	int zero_radius_sent = 0;
	longint cycles = 0;

	blade_section_cylinder_wrap_unit #(.FRAC_BITS(FRAC), .TRIG_STEPS(STEPS)) u_top (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// ---------------- predictor ----------------
	function automatic logic [31:0] clamp32(input longint v);
		if (v > 64'sd2147483647)
			return 32'h7fff_ffff;
		if (v < -64'sd2147483648)
			return 32'h8000_0000;
		return v[31:0];
	endfunction

	function automatic longint rnd30(input longint v);
		return (v + (64'sd1 <<< 29)) >>> 30;
	endfunction

	task automatic cordic_sincos(input longint ang, output longint s, output longint c);
		longint a, x, y, dx, dy;
		bit neg;
		a = ang % TWO_PI_A;
		x = GAIN;
		y = 0;
		neg = 1'b0;
		if (a > PI_A)
			a -= TWO_PI_A;
		else if (a < -PI_A)
			a += TWO_PI_A;
		// fold into the right half plane, negate both at the end
		if (a > HALF_PI_A) begin
			a -= PI_A;
			neg = 1'b1;
		end else if (a < -HALF_PI_A) begin
			a += PI_A;
			neg = 1'b1;
		end
		for (int i = 0; i < STEPS && i < bscw_pkg::CORDIC_TAB; i++) begin
			dx = y >>> i;
			dy = x >>> i;
			if (a >= 0) begin
				x -= dx;
				y += dy;
				a -= longint'(bscw_pkg::ATAN_Q30[i]);
			end else begin
				x += dx;
				y -= dy;
				a += longint'(bscw_pkg::ATAN_Q30[i]);
			end
		end
		s = neg ? -y : y;
		c = neg ? -x : x;
	endtask

	task automatic wrap_side(input longint r, input longint d, input longint t,
			input longint sp, input longint cp,
			output logic [31:0] ox, output logic [31:0] oy, output logic [31:0] oz);
		longint zf, uf, omega, so, co;
		zf = t * cp - d * sp;
		uf = d * cp + t * sp;
		omega = -(uf / r);
		cordic_sincos(omega, so, co);
		oz = clamp32(rnd30(zf));
		ox = clamp32(-rnd30(r * so));
		oy = clamp32(rnd30(r * co));
	endtask

	task automatic predict_wrap(input station_t st, output wrapped_pts_t p);
		longint r, d, pa, sp, cp;
		r = longint'({1'b0, st.radius});
		for (int k = 0; k < 6; k++)
			p.coord[k] = '0;
		p.err = (r == 0);
		if (r != 0) begin
			pa = longint'($signed(st.pitch)) <<< (30 - FRAC);
			cordic_sincos(pa, sp, cp);
			d = longint'($signed(st.pos)) - longint'($signed(st.skew));
			wrap_side(r, d, longint'($signed(st.back)), sp, cp,
				p.coord[0], p.coord[1], p.coord[2]);
			wrap_side(r, d, longint'($signed(st.face)), sp, cp,
				p.coord[3], p.coord[4], p.coord[5]);
		end
	endtask

	// ---------------- drivers ----------------
	task automatic send_station(input station_t st);
		wrapped_pts_t p;
		predict_wrap(st, p);
		s_tdata <= {5'd0, st.face, st.back, st.pos, st.pitch, st.skew, st.radius};
		s_tvalid <= 1'b1;
		do
			@(posedge clk);
		while (!s_tready);
		pts_pending.push_back(p);
		requests_sent++;
		if (st.radius == 0)
			zero_radius_sent++;
		// each following cycle idles with the set probability
		while ($urandom_range(0, 99) < tx_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
	endtask

	task automatic wait_drained();
		s_tvalid <= 1'b0;
		while (pts_pending.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	function automatic station_t rand_station();
		station_t st;
		int kind;
		kind = $urandom_range(0, 99);
		st.pitch = 20'($urandom);
		if (kind < 15) begin
			// fully random bits everywhere
			st.radius = 31'($urandom);
			st.skew = $urandom;
			st.pos = $urandom;
			st.back = $urandom;
			st.face = $urandom;
		end else begin
			// plausible blade geometry: radius 0.1..40, offsets of a few units
			st.radius = 31'($urandom_range(32'h0000_1999, 32'h0028_0000));
			st.skew = $signed($urandom_range(0, 32'h000c_0000)) - 32'sh0006_0000;
			st.pos = $signed($urandom_range(0, 32'h0010_0000)) - 32'sh0008_0000;
			st.back = $urandom_range(0, 32'h0002_0000);
			st.face = -$signed($urandom_range(0, 32'h0002_0000));
			st.pitch = 20'($signed($urandom_range(0, 20'h3_0000)) - 20'sh1_8000);
		end
		if (kind >= 97)
			st.radius = '0;
		return st;
	endfunction

	// ---------------- tests ----------------
	task automatic test_directed();
		station_t st;
		station_t base;
		base = '{radius: 31'h0005_0000, skew: 32'h0000_8000, pitch: 20'h0_c000,
			pos: 32'h0001_0000, back: 32'h0000_4000, face: 32'hffff_c000};
		tx_idle_pct = 0;
		rx_idle_pct = 0;
		send_station(base);
		st = base; st.radius = '0; send_station(st);
		st = base; st.radius = '0; st.skew = '1; st.back = '1; send_station(st);
		st = base; st.radius = 31'd1; send_station(st);
		st = base; st.radius = '1; send_station(st);
		st = base; st.pitch = 20'h7_ffff; send_station(st);
		st = base; st.pitch = 20'h8_0000; send_station(st);
		st = base; st.pitch = '0; send_station(st);
		// chord offset and thickness extremes, d spans the full 33 bit range
		st = base; st.pos = 32'h7fff_ffff; st.skew = 32'h8000_0000; send_station(st);
		st = base; st.pos = 32'h8000_0000; st.skew = 32'h7fff_ffff; send_station(st);
		st = base; st.back = 32'h7fff_ffff; st.face = 32'h8000_0000; send_station(st);
		st = base; st.back = 32'h8000_0000; st.face = 32'h7fff_ffff; send_station(st);
		// large omega from a tiny radius
		st = base; st.radius = 31'd1; st.pos = 32'h7fff_ffff; st.skew = 32'h8000_0000;
		send_station(st);
		// saturation of z and of x/y with the largest radius
		st = '{radius: '1, skew: 32'h8000_0000, pitch: 20'h1_921f,
			pos: 32'h7fff_ffff, back: 32'h7fff_ffff, face: 32'h8000_0000};
		send_station(st);
		st.pitch = 20'h8_0000; send_station(st);
		st = '{radius: '1, skew: '0, pitch: '0, pos: '0, back: '0, face: '0};
		send_station(st);
		st = '{radius: 31'h5555_5555, skew: 32'haaaa_aaaa, pitch: 20'h5_5555,
			pos: 32'h5555_5555, back: 32'haaaa_aaaa, face: 32'h5555_5555};
		send_station(st);
		wait_drained();
	endtask

	task automatic test_random(input int n, input int tx_pct, input int rx_pct);
		tx_idle_pct = tx_pct;
		rx_idle_pct = rx_pct;
		repeat (n) send_station(rand_station());
		wait_drained();
	endtask

	task automatic test_backpressure();
		tx_idle_pct = 0;
		rx_idle_pct = 10;
		stall_reqs++;
		repeat (350) send_station(rand_station());
		wait_drained();
		rx_idle_pct = 0;
	endtask

	// ---------------- receiver and checker ----------------
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else if (stall_cnt > 0) begin
			stall_cnt <= stall_cnt - 1;
			m_tready <= 1'b0;
		end else if (stall_served != stall_reqs) begin
			stall_served <= stall_reqs;
			stall_cnt <= 500;
			m_tready <= 1'b0;
		end else begin
			m_tready <= ($urandom_range(0, 99) >= rx_idle_pct);
		end
	end

	always @(posedge clk) begin
		wrapped_pts_t want;
		bit bad;
		if (arst_n && m_tvalid && m_tready) begin
			results_seen++;
			if (pts_pending.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("%0t: result with nothing outstanding: %h", $realtime, m_tdata);
			end else begin
				want = pts_pending.pop_front();
				bad = (m_tuser !== want.err);
				for (int k = 0; k < 6; k++)
					if (m_tdata[32*k +: 32] !== want.coord[k])
						bad = 1'b1;
				if (bad) begin
					mismatches++;
					if (mismatches <= 10)
						$display("%0t: result %0d exp err=%b %h %h %h %h %h %h got err=%b %h",
							$realtime, results_seen, want.err, want.coord[0], want.coord[1],
							want.coord[2], want.coord[3], want.coord[4], want.coord[5],
							m_tuser, m_tdata);
				end
			end
		end
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d pending", cycles, pts_pending.size());
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	initial begin
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_random(400, 23, 66);
		test_random(400, 66, 23);
		test_random(400, 0, 0);
		test_backpressure();
		if (pts_pending.size() != 0)
			mismatches++;
		$display("covered %0d stations (%0d zero radius), %0d results checked, %0d bad",
			requests_sent, zero_radius_sent, results_seen, mismatches);
		$display("phases: directed extremes, three idle mixes, long output stall");
		if (mismatches == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end
endmodule

/* blade_section_cylinder_wrap_unit.f */
+incdir+design
design/bscw_pkg.sv
design/bscw_sincos.sv
design/bscw_div.sv
design/bscw_lane.sv
design/blade_section_cylinder_wrap_unit.sv
design/bscw_checker.sv
verif/tb.sv
